@@ src/dfs_pkg.sv @@
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared sizes, status codes and operation codes for the graph traversal block.
// ----------------------------------------------------------------------------
package dfs_pkg;

    // Store sizes
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 128;
    localparam int STACK_DEPTH  = 256;

    // Field widths fixed by the item format
    localparam int VID_W    = 5;
    localparam int VCNT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // Derived sizes
    localparam int VERTEX_LIMIT = (MAX_VERTICES < (1 << VID_W)) ? MAX_VERTICES : (1 << VID_W);
    localparam int MARK_CNT     = 1 << VID_W;
    localparam int EDGE_AW      = $clog2(MAX_EDGES);
    localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W       = 2 * VID_W;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int LEVEL_W      = $clog2(STACK_DEPTH + 1);

    // Operation codes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_TRAVERSE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

endpackage

@@ src/dfs_graph_traversal.sv @@
// ----------------------------------------------------------------------------
// dfs_graph_traversal
// Directed edge store with an iterative depth-first walk over all vertices.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser=op, tdata=src,dst
//  m_axis    out        tvalid/tready, tlast   tdata=vertex, tuser=status
//  cfg       in         valid/ready            data=vertex_count
//
//  Add edge: a new transaction is accepted while the output register drains.
//  Traverse: each root is skipped or started, each stack pop runs through
//  pop, read and visit, and each visit scans the whole edge store, so the
//  edge memory read port sets the walk time.
//  Results are held one deep so the final one can carry tlast and status.
//  rst_n clears counters and marks at once; the memories need no clearing.
//  Input is taken only in the idle state with the output register free.
// ----------------------------------------------------------------------------
module dfs_graph_traversal (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dfs_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [4:0] src_vertex, [9:5] dst_vertex
    input  logic                               s_axis_tuser,   // [0] op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [dfs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [4:0] vertex
    output logic                               m_axis_tlast,
    output logic [dfs_pkg::STATUS_W-1:0]       m_axis_tuser,   // [1:0] status
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dfs_pkg::VCNT_W-1:0]         cfg_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ROOT    = 3'd1;
    localparam logic [2:0] S_POP     = 3'd2;
    localparam logic [2:0] S_POPWAIT = 3'd3;
    localparam logic [2:0] S_VISIT   = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    localparam logic [dfs_pkg::VCNT_W-1:0] RESET_COUNT =
        dfs_pkg::VCNT_W'(dfs_pkg::VERTEX_LIMIT);

    // Control state
    logic [2:0]                    state_reg, state_next;
    logic [dfs_pkg::VCNT_W-1:0]    vcount_reg, vcount_next;
    logic [dfs_pkg::ECNT_W-1:0]    edge_total_reg, edge_total_next;
    logic [dfs_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [dfs_pkg::VCNT_W-1:0]    root_reg, root_next;
    logic [dfs_pkg::ECNT_W-1:0]    scan_reg, scan_next;
    logic                          rvalid_reg, rvalid_next;
    logic [dfs_pkg::MARK_CNT-1:0]  visited_reg, visited_next;
    logic                          ovf_reg, ovf_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload state
    logic [dfs_pkg::VID_W-1:0]     v_reg, v_next;
    logic [dfs_pkg::VID_W-1:0]     pend_vertex_reg, pend_vertex_next;
    logic [dfs_pkg::VID_W-1:0]     out_vertex_reg, out_vertex_next;
    logic                          out_last_reg, out_last_next;
    logic [dfs_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    // Datapath
    logic                          out_free;
    logic                          in_fire;
    logic                          in_op;
    logic [dfs_pkg::VID_W-1:0]     in_src, in_dst;
    logic                          edge_we;
    logic [dfs_pkg::EDGE_W-1:0]    edge_rdata;
    logic [dfs_pkg::VID_W-1:0]     e_src, e_dst;
    logic                          issue;
    logic                          hit;
    logic                          room;
    logic                          push;
    logic [dfs_pkg::LEVEL_W-1:0]   lvl_dec;
    logic [dfs_pkg::VID_W-1:0]     stack_rdata;

    assign in_op  = s_axis_tuser;
    assign in_src = s_axis_tdata[dfs_pkg::VID_W-1:0];
    assign in_dst = s_axis_tdata[2*dfs_pkg::VID_W-1:dfs_pkg::VID_W];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dfs_pkg::OUT_DATA_W'(out_vertex_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    // Edge scan: decode the word read last cycle
    assign e_src   = edge_rdata[2*dfs_pkg::VID_W-1:dfs_pkg::VID_W];
    assign e_dst   = edge_rdata[dfs_pkg::VID_W-1:0];
    assign issue   = scan_reg < edge_total_reg;
    assign hit     = (state_reg == S_SCAN) && rvalid_reg && (e_src == v_reg)
                     && ({1'b0, e_dst} < vcount_reg) && !visited_reg[e_dst];
    assign room    = level_reg < dfs_pkg::LEVEL_W'(dfs_pkg::STACK_DEPTH);
    assign push    = hit && room;
    assign lvl_dec = level_reg - dfs_pkg::LEVEL_W'(1);

    dfs_ram #(
        .WIDTH (dfs_pkg::EDGE_W),
        .DEPTH (dfs_pkg::MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_total_reg[dfs_pkg::EDGE_AW-1:0]),
        .wdata ({in_src, in_dst}),
        .raddr (scan_reg[dfs_pkg::EDGE_AW-1:0]),
        .rdata (edge_rdata)
    );

    dfs_ram #(
        .WIDTH (dfs_pkg::VID_W),
        .DEPTH (dfs_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (push),
        .waddr (level_reg[dfs_pkg::STACK_AW-1:0]),
        .wdata (e_dst),
        .raddr (lvl_dec[dfs_pkg::STACK_AW-1:0]),
        .rdata (stack_rdata)
    );

    // Sequencer and result staging
    always_comb
    begin
        state_next       = state_reg;
        vcount_next      = vcount_reg;
        edge_total_next  = edge_total_reg;
        level_next       = level_reg;
        root_next        = root_reg;
        scan_next        = scan_reg;
        rvalid_next      = 1'b0;
        visited_next     = visited_reg;
        ovf_next         = ovf_reg;
        pend_valid_next  = pend_valid_reg;
        pend_vertex_next = pend_vertex_reg;
        v_next           = v_reg;
        out_vertex_next  = out_vertex_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        edge_we          = 1'b0;

        // Take a new vertex count, saturated to the vertex id range
        if (cfg_valid)
        begin
            vcount_next = (cfg_data > RESET_COUNT) ? RESET_COUNT : cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == dfs_pkg::OP_ADD_EDGE)
                    begin
                        out_valid_next  = 1'b1;
                        out_vertex_next = '0;
                        out_last_next   = 1'b1;
                        if (({1'b0, in_src} >= vcount_reg) || ({1'b0, in_dst} >= vcount_reg))
                        begin
                            out_status_next = dfs_pkg::ST_RANGE;
                        end
                        else if (edge_total_reg == dfs_pkg::ECNT_W'(dfs_pkg::MAX_EDGES))
                        begin
                            out_status_next = dfs_pkg::ST_FULL;
                        end
                        else
                        begin
                            out_status_next = dfs_pkg::ST_OK;
                            edge_we         = 1'b1;
                            edge_total_next = edge_total_reg + dfs_pkg::ECNT_W'(1);
                        end
                    end
                    else if (vcount_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_vertex_next = '0;
                        out_last_next   = 1'b1;
                        out_status_next = dfs_pkg::ST_RANGE;
                    end
                    else
                    begin
                        visited_next    = '0;
                        level_next      = '0;
                        root_next       = '0;
                        ovf_next        = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = S_ROOT;
                    end
                end
            end

            S_ROOT:
            begin
                if (root_reg >= vcount_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (visited_reg[root_reg[dfs_pkg::VID_W-1:0]])
                begin
                    root_next = root_reg + dfs_pkg::VCNT_W'(1);
                end
                else
                begin
                    // Pushing the root and popping it right away: go straight to visit
                    v_next     = root_reg[dfs_pkg::VID_W-1:0];
                    state_next = S_VISIT;
                end
            end

            S_POP:
            begin
                if (level_reg == '0)
                begin
                    root_next  = root_reg + dfs_pkg::VCNT_W'(1);
                    state_next = S_ROOT;
                end
                else
                begin
                    level_next = lvl_dec;
                    state_next = S_POPWAIT;
                end
            end

            S_POPWAIT:
            begin
                v_next     = stack_rdata;
                state_next = S_VISIT;
            end

            S_VISIT:
            begin
                if (visited_reg[v_reg])
                begin
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // Release the held result, hold this one
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_vertex_next = pend_vertex_reg;
                        out_last_next   = 1'b0;
                        out_status_next = dfs_pkg::ST_OK;
                    end
                    pend_valid_next       = 1'b1;
                    pend_vertex_next      = v_reg;
                    visited_next[v_reg]   = 1'b1;
                    scan_next             = '0;
                    state_next            = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    scan_next   = scan_reg + dfs_pkg::ECNT_W'(1);
                    rvalid_next = 1'b1;
                end
                else if (!rvalid_reg)
                begin
                    state_next = S_POP;
                end
                if (push)
                begin
                    level_next = level_reg + dfs_pkg::LEVEL_W'(1);
                end
                if (hit && !room)
                begin
                    ovf_next = 1'b1;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = pend_vertex_reg;
                    out_last_next   = 1'b1;
                    out_status_next = ovf_reg ? dfs_pkg::ST_OVERFLOW : dfs_pkg::ST_OK;
                    pend_valid_next = 1'b0;
                    level_next      = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= RESET_COUNT;
            edge_total_reg <= '0;
            level_reg      <= '0;
            root_reg       <= '0;
            scan_reg       <= '0;
            rvalid_reg     <= 1'b0;
            visited_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            edge_total_reg <= edge_total_next;
            level_reg      <= level_next;
            root_reg       <= root_next;
            scan_reg       <= scan_next;
            rvalid_reg     <= rvalid_next;
            visited_reg    <= visited_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        v_reg           <= v_next;
        pend_vertex_reg <= pend_vertex_next;
        out_vertex_reg  <= out_vertex_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

endmodule

@@ src/dfs_ram.sv @@
// ----------------------------------------------------------------------------
// dfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/dfs_checker.sv @@
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the traversal block, attached by bind.
// ----------------------------------------------------------------------------
module dfs_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [dfs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tlast,
    input  logic [dfs_pkg::STATUS_W-1:0]       m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Any error or overflow status ends the run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != dfs_pkg::ST_OK) |-> m_axis_tlast)
        else $error("non-ok status on a result that is not last");

    // Rejected transactions (full or range status) carry vertex zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == dfs_pkg::ST_FULL)
            || (m_axis_tuser == dfs_pkg::ST_RANGE)) |-> (m_axis_tdata == '0))
        else $error("rejected transaction carries a vertex");

    // An accepted add edge answers in the next cycle with a single last result
    a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == dfs_pkg::OP_ADD_EDGE) |=>
            m_axis_tvalid && m_axis_tlast && (m_axis_tdata == '0))
        else $error("add edge result missing");

endmodule

bind dfs_graph_traversal dfs_checker u_dfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the depth-first traversal block. A local predictor keeps its
// own edge list and vertex count, works out the status or visit sequence for
// each accepted transaction, and a checker compares every output transaction
// against the oldest expected one. Directed tests cover the edge cases around
// randomized phases that run under several vertex counts, most with random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [dfs_pkg::VID_W-1:0]    vertex;
        logic                         last;
        logic [dfs_pkg::STATUS_W-1:0] status;
    } walk_result_t;

    localparam int FIELD_VERTICES = 1 << dfs_pkg::VID_W;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [dfs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // [4:0] src_vertex, [9:5] dst_vertex
    logic                           s_axis_tuser = 1'b0; // [0] op
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [dfs_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // [4:0] vertex
    logic                           m_axis_tlast;
    logic [dfs_pkg::STATUS_W-1:0]   m_axis_tuser;        // [1:0] status
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dfs_pkg::VCNT_W-1:0]     cfg_data = '0;

    // Predictor state: edge list in insertion order and the vertex count
    logic [dfs_pkg::VID_W-1:0] edge_from [dfs_pkg::MAX_EDGES];
    logic [dfs_pkg::VID_W-1:0] edge_to [dfs_pkg::MAX_EDGES];
    int                        edges_held = 0;
    int                        vcount = 32;

    walk_result_t awaited_results [$];
    walk_result_t want;
    int           mismatches = 0;
    logic         no_idle = 1'b0;

    dfs_graph_traversal uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Vertex count as the block uses it, saturated to the store and field size
    function automatic int eff_count();
        int n;
        n = vcount;
        if (n > dfs_pkg::MAX_VERTICES)
            n = dfs_pkg::MAX_VERTICES;
        if (n > FIELD_VERTICES)
            n = FIELD_VERTICES;
        return n;
    endfunction

    // Draw an idle cycle for either side
    function automatic logic idle_now();
        return !no_idle && ($urandom_range(0, 99) < 21);
    endfunction

    // Append one expected result behind the others
    function automatic void queue_result(input walk_result_t r);
        awaited_results = {awaited_results, r};
    endfunction

    // Work out the results of one accepted transaction and queue them
    function automatic void predict_graph_op(input logic op,
                                             input logic [dfs_pkg::VID_W-1:0] src,
                                             input logic [dfs_pkg::VID_W-1:0] dst);
        int                        n;
        int                        depth;
        int                        hits;
        int                        root;
        int                        e;
        logic                      overflow;
        logic [dfs_pkg::VID_W-1:0] v;
        logic [dfs_pkg::VID_W-1:0] d;
        logic                      seen [dfs_pkg::MAX_VERTICES];
        logic [dfs_pkg::VID_W-1:0] walk_stack [dfs_pkg::STACK_DEPTH];
        walk_result_t              emitted [FIELD_VERTICES];
        walk_result_t              res;

        n = eff_count();
        res.vertex = '0;
        res.last   = 1'b1;
        res.status = dfs_pkg::ST_OK;
        if (op == dfs_pkg::OP_ADD_EDGE)
        begin
            // Range check wins over the full-store check
            if (src >= n || dst >= n)
                res.status = dfs_pkg::ST_RANGE;
            else if (edges_held >= dfs_pkg::MAX_EDGES)
                res.status = dfs_pkg::ST_FULL;
            else
            begin
                edge_from[edges_held] = src;
                edge_to[edges_held]   = dst;
                edges_held++;
            end
            queue_result(res);
        end
        else if (n == 0)
        begin
            res.status = dfs_pkg::ST_RANGE;
            queue_result(res);
        end
        else
        begin
            hits     = 0;
            depth    = 0;
            overflow = 1'b0;
            for (int i = 0; i < dfs_pkg::MAX_VERTICES; i++)
                seen[i] = 1'b0;
            for (root = 0; root < n; root++)
            begin
                if (seen[root])
                    continue;
                if (depth >= dfs_pkg::STACK_DEPTH)
                    overflow = 1'b1;
                else
                begin
                    walk_stack[depth] = dfs_pkg::VID_W'(root);
                    depth++;
                end
                while (depth > 0)
                begin
                    depth--;
                    v = walk_stack[depth];
                    if (v >= n)
                        continue;
                    if (!seen[v])
                    begin
                        seen[v] = 1'b1;
                        if (hits < FIELD_VERTICES)
                        begin
                            emitted[hits].vertex = v;
                            emitted[hits].last   = 1'b0;
                            emitted[hits].status = dfs_pkg::ST_OK;
                            hits++;
                        end
                    end
                    // Scan every out-edge, even of an already visited vertex
                    for (e = 0; e < edges_held; e++)
                    begin
                        if (edge_from[e] != v)
                            continue;
                        d = edge_to[e];
                        if (d >= n || seen[d])
                            continue;
                        if (depth >= dfs_pkg::STACK_DEPTH)
                            overflow = 1'b1;
                        else
                        begin
                            walk_stack[depth] = d;
                            depth++;
                        end
                    end
                end
            end
            emitted[hits-1].last = 1'b1;
            if (overflow)
                emitted[hits-1].status = dfs_pkg::ST_OVERFLOW;
            for (int i = 0; i < hits; i++)
                queue_result(emitted[i]);
        end
    endfunction

    // Output side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= !idle_now();
    end

    // Compare each output transaction with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result vertex %0d last %0d status %0d", $time,
                         m_axis_tdata[dfs_pkg::VID_W-1:0], m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[dfs_pkg::VID_W-1:0] !== want.vertex)
                begin
                    $display("%0t: vertex expected %0d actual %0d", $time,
                             want.vertex, m_axis_tdata[dfs_pkg::VID_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: tlast expected %0d actual %0d", $time,
                             want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Send one transaction with a random lead-in gap, then predict it
    task automatic send_item(input logic op, input logic [dfs_pkg::VID_W-1:0] src,
                             input logic [dfs_pkg::VID_W-1:0] dst);
        while (idle_now())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= dfs_pkg::IN_DATA_W'({dst, src});
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_graph_op(op, src, dst);
    endtask

    // Drop valid and let every expected result drain, then settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the vertex count once the block is idle
    task automatic write_vertex_count(input logic [dfs_pkg::VCNT_W-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vcount = value;
    endtask

    // Empty graph at the reset count: every vertex becomes its own root
    task automatic test_walk_empty_graph();
        send_item(dfs_pkg::OP_TRAVERSE, dfs_pkg::VID_W'($urandom),
                  dfs_pkg::VID_W'($urandom));
    endtask

    // Edge loads at the field extremes, self loops, then a walk
    task automatic test_edge_loads();
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd0, 5'd1);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd1, 5'd2);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd0, 5'd3);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd31, 5'd0);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd31, 5'd31);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd2, 5'd1);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd31, 5'd31);
    endtask

    // Out-of-range source or destination, on and around the boundary
    task automatic test_range_reject();
        write_vertex_count(6'd20);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd25, 5'd1);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd1, 5'd25);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd20, 5'd0);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd19, 5'd19);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd0, 5'd0);
    endtask

    // Zero vertices: every transaction answers with a range status
    task automatic test_zero_count();
        write_vertex_count(6'd0);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd0, 5'd0);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd0, 5'd0);
    endtask

    // Saturated count, then edges left pointing past a smaller count
    task automatic test_stale_edges();
        write_vertex_count(6'd63);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd3, 5'd30);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd4, 5'd5);
        write_vertex_count(6'd8);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd3, 5'd30);
        write_vertex_count(6'd1);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd0, 5'd0);
    endtask

    // Random phases: mostly in-range edges, some noise, a few walks
    task automatic test_random_mix();
        int                         plan [10] = '{5, 32, 1, 12, 63, 0, 2, 24, -1, -1};
        int                         pick;
        int                         n;
        logic [dfs_pkg::VCNT_W-1:0] setting;

        for (int phase = 0; phase < 10; phase++)
        begin
            setting = (plan[phase] < 0) ? dfs_pkg::VCNT_W'($urandom_range(0, 63))
                                        : dfs_pkg::VCNT_W'(plan[phase]);
            write_vertex_count(setting);
            no_idle = (phase == 3);
            n = eff_count();
            for (int k = 0; k < 40; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_item(dfs_pkg::OP_TRAVERSE, dfs_pkg::VID_W'($urandom),
                              dfs_pkg::VID_W'($urandom));
                else if (pick < 90 && n > 0)
                    send_item(dfs_pkg::OP_ADD_EDGE,
                              dfs_pkg::VID_W'($urandom_range(0, n - 1)),
                              dfs_pkg::VID_W'($urandom_range(0, n - 1)));
                else
                    send_item(dfs_pkg::OP_ADD_EDGE, dfs_pkg::VID_W'($urandom),
                              dfs_pkg::VID_W'($urandom));
            end
            no_idle = 1'b0;
        end
    endtask

    // Fill the edge store, overrun it, and check range still wins when full
    task automatic test_store_full();
        write_vertex_count(6'd32);
        while (edges_held < dfs_pkg::MAX_EDGES)
            send_item(dfs_pkg::OP_ADD_EDGE, dfs_pkg::VID_W'($urandom),
                      dfs_pkg::VID_W'($urandom));
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd0, 5'd31);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd31, 5'd0);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd0, 5'd0);
        write_vertex_count(6'd10);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd15, 5'd0);
        send_item(dfs_pkg::OP_ADD_EDGE, 5'd9, 5'd9);
        send_item(dfs_pkg::OP_TRAVERSE, 5'd0, 5'd0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_walk_empty_graph();
        test_edge_loads();
        test_range_reject();
        test_zero_count();
        test_stale_edges();
        test_random_mix();
        test_store_full();
        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Hard stop: ends the run if the block or the bench hangs
    initial
    begin
        #500_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
